// File: rtl/qslerp_pkg.sv
`timescale 1ns / 1ps
// Shared constants and the arctangent table for the quaternion SLERP core.
// Used by qslerp_cordic, qslerp_div and quaternion_slerp_core; no dependencies.
package qslerp_pkg;

  localparam int CW        = 16;              // quaternion component width, Q1.14
  localparam int FRAC_W    = 17;              // interpolation fraction, Q1.16
  localparam int ITER_DEF  = 16;              // default CORDIC micro-rotations
  localparam int XW        = 34;              // CORDIC x/y/z datapath width
  localparam int ROOT_BITS = 31;              // square root result bits
  localparam int RAD_W     = 61;              // radicand width, 1 - d*d in Q60
  localparam int NUM_W     = 56;              // weight dividend width
  localparam int DEN_W     = 31;              // weight divisor width
  localparam int QBITS     = 32;              // weight quotient bits
  localparam int SIDE_W    = 8 * CW + FRAC_W; // components plus fraction

  localparam logic signed [XW-1:0] ANG_PI        = 34'sd3373259426;
  localparam logic signed [XW-1:0] ANG_HALF_PI   = 34'sd1686629713;
  localparam logic signed [XW-1:0] ONE_Q30       = 34'sd1073741824;
  localparam logic signed [XW-1:0] SIN_NEAR_ZERO = 34'sd33554432;
  localparam logic [QBITS-1:0]     WEIGHT_MAX    = 32'd1073741824;
  localparam logic [FRAC_W-1:0]    FRAC_ONE      = 17'd65536;

  // atan(2^-k) in Q30 radians, rounded to nearest
  function automatic logic signed [XW-1:0] atan_q30(input int k);
    logic signed [XW-1:0] a;
    case (k)
      0:  a = 34'sd843314857;
      1:  a = 34'sd497837829;
      2:  a = 34'sd263043837;
      3:  a = 34'sd133525159;
      4:  a = 34'sd67021688;
      5:  a = 34'sd33543516;
      6:  a = 34'sd16775851;
      7:  a = 34'sd8388437;
      8:  a = 34'sd4194283;
      9:  a = 34'sd2097149;
      10: a = 34'sd1048576;
      11: a = 34'sd524288;
      12: a = 34'sd262144;
      13: a = 34'sd131072;
      14: a = 34'sd65536;
      15: a = 34'sd32768;
      16: a = 34'sd16384;
      17: a = 34'sd8192;
      18: a = 34'sd4096;
      19: a = 34'sd2048;
      20: a = 34'sd1024;
      21: a = 34'sd512;
      22: a = 34'sd256;
      23: a = 34'sd128;
      24: a = 34'sd64;
      25: a = 34'sd32;
      26: a = 34'sd16;
      27: a = 34'sd8;
      28: a = 34'sd4;
      29: a = 34'sd2;
      30: a = 34'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

  // fold an angle in [0, pi] into [0, pi/2] for the sine
  function automatic logic signed [XW-1:0] sin_fold(input logic signed [XW-1:0] z);
    return (z > ANG_HALF_PI) ? (ANG_PI - z) : z;
  endfunction

endpackage

// File: rtl/quaternion_slerp_core.sv
`timescale 1ns / 1ps
// Quaternion SLERP top level: dot product, square root, arccosine, sines,
// weight division and blend. Depends on qslerp_pkg, qslerp_cordic, qslerp_div.
//
//  channel | ports                                     | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid, in_stall, in_a_*, in_b_*,        | in
//          | in_fraction                                |
//  result  | out_valid, out_stall, out_x/y/z/w          | out
//
// One item enters per cycle while in_stall is low; the pipeline is built from
// the 31-stage square root, the 32-stage weight divider and two CORDIC chains.
// Synchronous active-low reset clears the valid chain only.
// A stalled result freezes the whole pipeline; in_stall rises with it.
module quaternion_slerp_core #(
  parameter int TRIG_ITERATIONS = qslerp_pkg::ITER_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [qslerp_pkg::CW-1:0]   in_a_x,
  input  logic signed [qslerp_pkg::CW-1:0]   in_a_y,
  input  logic signed [qslerp_pkg::CW-1:0]   in_a_z,
  input  logic signed [qslerp_pkg::CW-1:0]   in_a_w,
  input  logic signed [qslerp_pkg::CW-1:0]   in_b_x,
  input  logic signed [qslerp_pkg::CW-1:0]   in_b_y,
  input  logic signed [qslerp_pkg::CW-1:0]   in_b_z,
  input  logic signed [qslerp_pkg::CW-1:0]   in_b_w,
  input  logic [qslerp_pkg::FRAC_W-1:0]      in_fraction,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [qslerp_pkg::CW-1:0]   out_x,
  output logic signed [qslerp_pkg::CW-1:0]   out_y,
  output logic signed [qslerp_pkg::CW-1:0]   out_z,
  output logic signed [qslerp_pkg::CW-1:0]   out_w
);

  localparam int CW        = qslerp_pkg::CW;
  localparam int FW        = qslerp_pkg::FRAC_W;
  localparam int XW        = qslerp_pkg::XW;
  localparam int SW        = qslerp_pkg::SIDE_W;
  localparam int RB        = qslerp_pkg::ROOT_BITS;
  localparam int RAD_W     = qslerp_pkg::RAD_W;
  localparam int NUM_W     = qslerp_pkg::NUM_W;
  localparam int DEN_W     = qslerp_pkg::DEN_W;
  localparam int QBITS     = qslerp_pkg::QBITS;
  localparam int CS_W      = 4 * CW;                 // one quaternion packed
  localparam int LAT       = 3 + RB + TRIG_ITERATIONS + 2 + TRIG_ITERATIONS + 1 + QBITS + 3;
  localparam int IDX_T     = 3 + RB + TRIG_ITERATIONS;  // theta register
  localparam int IDX_W     = LAT - 3;                   // weight register
  localparam logic [RAD_W-1:0] ONE_Q60 = RAD_W'(1) << 60;
  localparam logic signed [31:0] WMAX_S = 32'sd1073741824;
  localparam logic signed [24:0] OUT_HI = 25'sd32767;
  localparam logic signed [24:0] OUT_LO = -25'sd32768;

  logic en;
  logic [LAT-1:0] vld_r, vld_nxt;

  assign en       = !vld_r[LAT-1] || !out_stall;
  assign in_stall = !en;
  assign vld_nxt  = {vld_r[LAT-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  // products and fraction saturation
  logic [FW-1:0]        f_sat;
  logic [SW-1:0]        side_in;
  logic signed [31:0]   prod_nxt [4];
  logic signed [31:0]   prod_r   [4];
  logic [SW-1:0]        side1_r;

  assign f_sat   = (in_fraction > qslerp_pkg::FRAC_ONE) ? qslerp_pkg::FRAC_ONE : in_fraction;
  assign side_in = {in_a_x, in_a_y, in_a_z, in_a_w, in_b_x, in_b_y, in_b_z, in_b_w, f_sat};

  always_comb begin
    prod_nxt[0] = 32'(in_a_x) * 32'(in_b_x);
    prod_nxt[1] = 32'(in_a_y) * 32'(in_b_y);
    prod_nxt[2] = 32'(in_a_z) * 32'(in_b_z);
    prod_nxt[3] = 32'(in_a_w) * 32'(in_b_w);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r  <= prod_nxt;
      side1_r <= side_in;
    end
  end

  // dot product in Q30, clamped to [-1, 1]
  logic signed [35:0] dsum;
  logic signed [31:0] dot_nxt, dot_r;
  logic [SW-1:0]      side2_r;

  always_comb begin
    dsum = (36'(prod_r[0]) + 36'(prod_r[1]) + 36'(prod_r[2]) + 36'(prod_r[3])) <<< 2;
    if (dsum > 36'(qslerp_pkg::ONE_Q30)) begin
      dot_nxt = 32'(qslerp_pkg::ONE_Q30);
    end else if (dsum < -36'(qslerp_pkg::ONE_Q30)) begin
      dot_nxt = -32'(qslerp_pkg::ONE_Q30);
    end else begin
      dot_nxt = dsum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dot_r   <= dot_nxt;
      side2_r <= side1_r;
    end
  end

  // d squared
  logic signed [63:0] dsq_full;
  logic [RAD_W-1:0]   dsq_r;
  logic signed [31:0] dot3_r;
  logic [SW-1:0]      side3_r;

  assign dsq_full = 64'(dot_r) * 64'(dot_r);

  always_ff @(posedge clk) begin
    if (en) begin
      dsq_r   <= dsq_full[RAD_W-1:0];
      dot3_r  <= dot_r;
      side3_r <= side2_r;
    end
  end

  // floor(sqrt(1 - d*d)), one root bit per stage
  logic [RAD_W-1:0]   rem_w  [RB+1];
  logic [RB-1:0]      root_w [RB+1];
  logic signed [31:0] sd_w   [RB+1];
  logic [SW-1:0]      ss_w   [RB+1];
  logic [RAD_W-1:0]   rem_r  [RB];
  logic [RB-1:0]      root_r [RB];
  logic signed [31:0] sd_r   [RB];
  logic [SW-1:0]      ss_r   [RB];

  assign rem_w[0]  = ONE_Q60 - dsq_r;
  assign root_w[0] = '0;
  assign sd_w[0]   = dot3_r;
  assign ss_w[0]   = side3_r;

  for (genvar j = 0; j < RB; j++) begin : g_sqrt
    localparam int K = RB - 1 - j;
    logic [62:0]      trial;
    logic [RAD_W-1:0] rem_nxt;
    logic [RB-1:0]    root_nxt;

    always_comb begin
      trial = (63'(root_w[j]) << (K + 1)) + (63'(1) << (2 * K));
      if (63'(rem_w[j]) >= trial) begin
        rem_nxt  = rem_w[j] - trial[RAD_W-1:0];
        root_nxt = root_w[j] | (RB'(1) << K);
      end else begin
        rem_nxt  = rem_w[j];
        root_nxt = root_w[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= rem_nxt;
        root_r[j] <= root_nxt;
        sd_r[j]   <= sd_w[j];
        ss_r[j]   <= ss_w[j];
      end
    end

    assign rem_w[j+1]  = rem_r[j];
    assign root_w[j+1] = root_r[j];
    assign sd_w[j+1]   = sd_r[j];
    assign ss_w[j+1]   = ss_r[j];
  end

  // arccosine by vectoring, pre-rotated by pi/2 for negative d
  logic signed [XW-1:0] ac_x, ac_y, ac_z, ac_z_o;
  logic signed [XW-1:0] ac_s, ac_d;
  logic [SW-1:0]        ac_side_o;

  always_comb begin
    ac_s = $signed({{(XW-RB){1'b0}}, root_w[RB]});
    ac_d = XW'(sd_w[RB]);
    if (ac_d < 0) begin
      ac_x = ac_s;
      ac_y = -ac_d;
      ac_z = qslerp_pkg::ANG_HALF_PI;
    end else begin
      ac_x = ac_d;
      ac_y = ac_s;
      ac_z = '0;
    end
  end

  qslerp_cordic #(
    .ITER      (TRIG_ITERATIONS),
    .SIDE_W    (SW),
    .VECTORING (1'b1)
  ) u_acos (
    .clk    (clk),
    .en     (en),
    .x_i    (ac_x),
    .y_i    (ac_y),
    .z_i    (ac_z),
    .side_i (ss_w[RB]),
    .x_o    (),
    .y_o    (),
    .z_o    (ac_z_o),
    .side_o (ac_side_o)
  );

  // clamp theta to [0, pi]
  logic [31:0]   theta_nxt, theta_r;
  logic [SW-1:0] side_t_r;

  always_comb begin
    if (ac_z_o < 0) begin
      theta_nxt = '0;
    end else if (ac_z_o > qslerp_pkg::ANG_PI) begin
      theta_nxt = qslerp_pkg::ANG_PI[31:0];
    end else begin
      theta_nxt = ac_z_o[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      theta_r  <= theta_nxt;
      side_t_r <= ac_side_o;
    end
  end

  // angle split: u = round(t * theta)
  logic [48:0]   tu_prod;
  logic [31:0]   u_r, theta_u_r;
  logic [SW-1:0] side_u_r;

  assign tu_prod = 49'(theta_r) * 49'(side_t_r[FW-1:0]) + 49'd32768;

  always_ff @(posedge clk) begin
    if (en) begin
      u_r       <= tu_prod[47:16];
      theta_u_r <= theta_r;
      side_u_r  <= side_t_r;
    end
  end

  // three sines in parallel; the side data rides along split across lanes
  logic signed [XW-1:0] z_th, z_u, z_v;
  logic signed [XW-1:0] sin_th, sin_u, sin_v;
  logic [CS_W-1:0]      sa_side, sb_side;
  logic [FW-1:0]        sf_side;

  assign z_th = $signed({2'b00, theta_u_r});
  assign z_u  = $signed({2'b00, u_r});
  assign z_v  = z_th - z_u;

  qslerp_cordic #(
    .ITER      (TRIG_ITERATIONS),
    .SIDE_W    (CS_W),
    .VECTORING (1'b0)
  ) u_sin_th (
    .clk    (clk),
    .en     (en),
    .x_i    (qslerp_pkg::ONE_Q30),
    .y_i    ('0),
    .z_i    (qslerp_pkg::sin_fold(z_th)),
    .side_i (side_u_r[SW-1 -: CS_W]),
    .x_o    (),
    .y_o    (sin_th),
    .z_o    (),
    .side_o (sa_side)
  );

  qslerp_cordic #(
    .ITER      (TRIG_ITERATIONS),
    .SIDE_W    (CS_W),
    .VECTORING (1'b0)
  ) u_sin_v (
    .clk    (clk),
    .en     (en),
    .x_i    (qslerp_pkg::ONE_Q30),
    .y_i    ('0),
    .z_i    (qslerp_pkg::sin_fold(z_v)),
    .side_i (side_u_r[FW +: CS_W]),
    .x_o    (),
    .y_o    (sin_v),
    .z_o    (),
    .side_o (sb_side)
  );

  qslerp_cordic #(
    .ITER      (TRIG_ITERATIONS),
    .SIDE_W    (FW),
    .VECTORING (1'b0)
  ) u_sin_u (
    .clk    (clk),
    .en     (en),
    .x_i    (qslerp_pkg::ONE_Q30),
    .y_i    ('0),
    .z_i    (qslerp_pkg::sin_fold(z_u)),
    .side_i (side_u_r[FW-1:0]),
    .x_o    (),
    .y_o    (sin_u),
    .z_o    (),
    .side_o (sf_side)
  );

  // dividends |sin| * 2^24 + sin(theta) / 2
  logic signed [XW-1:0] mag_a, mag_b, st_half;
  logic [NUM_W-1:0]     num_a_r, num_b_r;
  logic [DEN_W-1:0]     den_r;
  logic                 sgn_a_r, sgn_b_r, near_r;
  logic [SW-1:0]        side_n_r;

  assign mag_a   = sin_v[XW-1] ? -sin_v : sin_v;
  assign mag_b   = sin_u[XW-1] ? -sin_u : sin_u;
  assign st_half = sin_th >>> 1;

  always_ff @(posedge clk) begin
    if (en) begin
      num_a_r  <= {mag_a[DEN_W-1:0], 24'd0} + NUM_W'(st_half[DEN_W-1:0]);
      num_b_r  <= {mag_b[DEN_W-1:0], 24'd0} + NUM_W'(st_half[DEN_W-1:0]);
      den_r    <= sin_th[DEN_W-1:0];
      sgn_a_r  <= sin_v[XW-1];
      sgn_b_r  <= sin_u[XW-1];
      near_r   <= (sin_th < qslerp_pkg::SIN_NEAR_ZERO);
      side_n_r <= {sa_side, sb_side, sf_side};
    end
  end

  logic [QBITS-1:0] quo_a, quo_b;
  logic [SW+1:0]    div_side_o;
  logic             sgn_b_o;

  qslerp_div #(
    .SIDE_W (SW + 2)
  ) u_div_a (
    .clk    (clk),
    .en     (en),
    .num_i  (num_a_r),
    .den_i  (den_r),
    .side_i ({near_r, sgn_a_r, side_n_r}),
    .quo_o  (quo_a),
    .side_o (div_side_o)
  );

  qslerp_div #(
    .SIDE_W (1)
  ) u_div_b (
    .clk    (clk),
    .en     (en),
    .num_i  (num_b_r),
    .den_i  (den_r),
    .side_i (sgn_b_r),
    .quo_o  (quo_b),
    .side_o (sgn_b_o)
  );

  // Q24 weights: saturated quotients, or linear near sin(theta) = 0
  logic               near_o, sgn_a_o;
  logic [FW-1:0]      f_o;
  logic [QBITS-1:0]   qa_sat, qb_sat;
  logic signed [31:0] wa_nxt, wb_nxt, wa_r, wb_r;
  logic [2*CS_W-1:0]  side_w_r;

  assign near_o  = div_side_o[SW+1];
  assign sgn_a_o = div_side_o[SW];
  assign f_o     = div_side_o[FW-1:0];
  assign qa_sat  = (quo_a > qslerp_pkg::WEIGHT_MAX) ? qslerp_pkg::WEIGHT_MAX : quo_a;
  assign qb_sat  = (quo_b > qslerp_pkg::WEIGHT_MAX) ? qslerp_pkg::WEIGHT_MAX : quo_b;

  always_comb begin
    if (near_o) begin
      wa_nxt = $signed({7'd0, qslerp_pkg::FRAC_ONE - f_o, 8'd0});
      wb_nxt = $signed({7'd0, f_o, 8'd0});
    end else begin
      wa_nxt = sgn_a_o ? -$signed(qa_sat) : $signed(qa_sat);
      wb_nxt = sgn_b_o ? -$signed(qb_sat) : $signed(qb_sat);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wa_r     <= wa_nxt;
      wb_r     <= wb_nxt;
      side_w_r <= div_side_o[SW-1:FW];
    end
  end

  // blend products
  logic signed [47:0] pa_nxt [4];
  logic signed [47:0] pb_nxt [4];
  logic signed [47:0] pa_r   [4];
  logic signed [47:0] pb_r   [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      pa_nxt[i] = 48'($signed(side_w_r[2*CS_W-1-CW*i -: CW])) * 48'(wa_r);
      pb_nxt[i] = 48'($signed(side_w_r[CS_W-1-CW*i -: CW])) * 48'(wb_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r <= pa_nxt;
      pb_r <= pb_nxt;
    end
  end

  // round half up, drop 24 fraction bits, saturate
  logic signed [48:0]   acc  [4];
  logic signed [24:0]   shr  [4];
  logic signed [CW-1:0] res_nxt [4];
  logic signed [CW-1:0] res_r   [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      acc[i] = 49'(pa_r[i]) + 49'(pb_r[i]) + 49'sd8388608;
      shr[i] = acc[i][48:24];
      if (shr[i] > OUT_HI) begin
        res_nxt[i] = OUT_HI[CW-1:0];
      end else if (shr[i] < OUT_LO) begin
        res_nxt[i] = OUT_LO[CW-1:0];
      end else begin
        res_nxt[i] = shr[i][CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = vld_r[LAT-1];
  assign out_x     = res_r[0];
  assign out_y     = res_r[1];
  assign out_z     = res_r[2];
  assign out_w     = res_r[3];

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> vld_r[0])
    else $error("accepted item did not enter the pipeline");

  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("valid chain moved during a stall");

  a_theta_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[IDX_T] |-> (theta_r <= qslerp_pkg::ANG_PI[31:0]))
    else $error("theta outside [0, pi]");

  a_weight_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[IDX_W] |-> (wa_r <= WMAX_S && wa_r >= -WMAX_S && wb_r <= WMAX_S && wb_r >= -WMAX_S))
    else $error("weight beyond saturation bound");

endmodule

// File: rtl/qslerp_cordic.sv
`timescale 1ns / 1ps
// Pipelined CORDIC, one register stage per micro-rotation, rotation or vectoring.
// Depends on qslerp_pkg for the datapath width and the arctangent table.
module qslerp_cordic #(
  parameter int ITER      = qslerp_pkg::ITER_DEF,
  parameter int SIDE_W    = 1,
  parameter bit VECTORING = 1'b0
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [qslerp_pkg::XW-1:0] x_i,
  input  logic signed [qslerp_pkg::XW-1:0] y_i,
  input  logic signed [qslerp_pkg::XW-1:0] z_i,
  input  logic [SIDE_W-1:0]               side_i,
  output logic signed [qslerp_pkg::XW-1:0] x_o,
  output logic signed [qslerp_pkg::XW-1:0] y_o,
  output logic signed [qslerp_pkg::XW-1:0] z_o,
  output logic [SIDE_W-1:0]               side_o
);

  localparam int XW = qslerp_pkg::XW;

  logic signed [XW-1:0] x_w [ITER+1];
  logic signed [XW-1:0] y_w [ITER+1];
  logic signed [XW-1:0] z_w [ITER+1];
  logic [SIDE_W-1:0]    s_w [ITER+1];

  logic signed [XW-1:0] x_r [ITER];
  logic signed [XW-1:0] y_r [ITER];
  logic signed [XW-1:0] z_r [ITER];
  logic [SIDE_W-1:0]    s_r [ITER];

  assign x_w[0] = x_i;
  assign y_w[0] = y_i;
  assign z_w[0] = z_i;
  assign s_w[0] = side_i;

  for (genvar i = 0; i < ITER; i++) begin : g_iter
    logic signed [XW-1:0] x_nxt;
    logic signed [XW-1:0] y_nxt;
    logic signed [XW-1:0] z_nxt;
    logic                 pos;

    always_comb begin
      // vectoring drives y toward zero, rotation drives z toward zero
      pos = VECTORING ? y_w[i][XW-1] : !z_w[i][XW-1];
      if (pos) begin
        x_nxt = x_w[i] - (y_w[i] >>> i);
        y_nxt = y_w[i] + (x_w[i] >>> i);
        z_nxt = z_w[i] - qslerp_pkg::atan_q30(i);
      end else begin
        x_nxt = x_w[i] + (y_w[i] >>> i);
        y_nxt = y_w[i] - (x_w[i] >>> i);
        z_nxt = z_w[i] + qslerp_pkg::atan_q30(i);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i] <= x_nxt;
        y_r[i] <= y_nxt;
        z_r[i] <= z_nxt;
        s_r[i] <= s_w[i];
      end
    end

    assign x_w[i+1] = x_r[i];
    assign y_w[i+1] = y_r[i];
    assign z_w[i+1] = z_r[i];
    assign s_w[i+1] = s_r[i];
  end

  assign x_o    = x_w[ITER];
  assign y_o    = y_w[ITER];
  assign z_o    = z_w[ITER];
  assign side_o = s_w[ITER];

endmodule

// File: rtl/qslerp_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on qslerp_pkg for the dividend, divisor and quotient widths.
module qslerp_div #(
  parameter int SIDE_W = 1
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic [qslerp_pkg::NUM_W-1:0]    num_i,
  input  logic [qslerp_pkg::DEN_W-1:0]    den_i,
  input  logic [SIDE_W-1:0]               side_i,
  output logic [qslerp_pkg::QBITS-1:0]    quo_o,
  output logic [SIDE_W-1:0]               side_o
);

  localparam int NUM_W = qslerp_pkg::NUM_W;
  localparam int DEN_W = qslerp_pkg::DEN_W;
  localparam int QBITS = qslerp_pkg::QBITS;
  localparam int CMP_W = DEN_W + QBITS;

  logic [NUM_W-1:0]  rem_w [QBITS+1];
  logic [QBITS-1:0]  quo_w [QBITS+1];
  logic [DEN_W-1:0]  den_w [QBITS+1];
  logic [SIDE_W-1:0] s_w   [QBITS+1];

  logic [NUM_W-1:0]  rem_r [QBITS];
  logic [QBITS-1:0]  quo_r [QBITS];
  logic [DEN_W-1:0]  den_r [QBITS];
  logic [SIDE_W-1:0] s_r   [QBITS];

  assign rem_w[0] = num_i;
  assign quo_w[0] = '0;
  assign den_w[0] = den_i;
  assign s_w[0]   = side_i;

  for (genvar j = 0; j < QBITS; j++) begin : g_bit
    localparam int K = QBITS - 1 - j;
    logic [CMP_W-1:0] sub;
    logic [NUM_W-1:0] rem_nxt;
    logic [QBITS-1:0] quo_nxt;

    always_comb begin
      sub = CMP_W'(den_w[j]) << K;
      if (CMP_W'(rem_w[j]) >= sub) begin
        rem_nxt = rem_w[j] - sub[NUM_W-1:0];
        quo_nxt = quo_w[j] | (QBITS'(1) << K);
      end else begin
        rem_nxt = rem_w[j];
        quo_nxt = quo_w[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= rem_nxt;
        quo_r[j] <= quo_nxt;
        den_r[j] <= den_w[j];
        s_r[j]   <= s_w[j];
      end
    end

    assign rem_w[j+1] = rem_r[j];
    assign quo_w[j+1] = quo_r[j];
    assign den_w[j+1] = den_r[j];
    assign s_w[j+1]   = s_r[j];
  end

  assign quo_o  = quo_w[QBITS];
  assign side_o = s_w[QBITS];

endmodule
